### rtl/core/esctok_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esctok_pkg
// Shared types and constants of the escaped text tokenizer.
// ----------------------------------------------------------------------------
package esctok_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRACKET     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EMBED_NL    = 2'd2;

    localparam logic [15:0] BRACKET_RESET  = 16'd257;
    localparam logic [15:0] EMBED_NL_RESET = 16'd256;

    // characters of interest
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_BAR       = 8'h7C;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;

    // result kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic        token_mode;
        logic [15:0] bracket_code;
        logic [15:0] embedded_newline_code;
    } t_cfg;

    typedef struct packed {
        logic       kind;
        logic [7:0] out_char;
        logic       line_end;
        logic       last;
    } t_result;

endpackage

### rtl/core/esctok_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esctok_in_if
// Input channel: one raw byte or an end-of-stream mark per item.
// ----------------------------------------------------------------------------
interface esctok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

### rtl/core/esctok_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esctok_out_if
// Result channel: token characters and end-of-token marks.
// ----------------------------------------------------------------------------
interface esctok_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] out_char;
    logic       line_end;
    logic       last;

    modport source (output valid, output kind, output out_char, output line_end,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_char, input line_end,
                    input last, output ready);
endinterface

### rtl/core/esctok_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esctok_decode
// Escape decoder and token splitter: holds the escape phase and the number
// accumulator, and turns each accepted item into up to two results.
// ----------------------------------------------------------------------------
module esctok_decode
    import esctok_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_eoi,
    input  t_cfg       i_cfg,
    output logic [1:0] o_res_cnt,
    output t_result    o_res [2]
);

    localparam int CW = (VALUE_WIDTH > 16) ? VALUE_WIDTH : 16;

    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_ESC   = 2'd1,
        PH_DEC   = 2'd2,
        PH_OCT   = 2'd3
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [VALUE_WIDTH-1:0] r_num, n_num;

    // tokenizer view of one decoded value
    function automatic t_result deliver(input logic [CW-1:0] v, input t_cfg cfg);
        t_result     r;
        logic [CW-1:0] nv;
        r  = '0;
        nv = v;
        if (v == CW'(CH_NEWLINE) || (v == CW'(CH_SPACE) && !cfg.token_mode)) begin
            r.kind     = KIND_END;
            r.line_end = (v == CW'(CH_NEWLINE));
        end else begin
            if (v == CW'(cfg.embedded_newline_code)) begin
                nv = CW'(CH_NEWLINE);
            end
            r.kind     = KIND_CHAR;
            r.out_char = nv[7:0];
        end
        return r;
    endfunction

    t_result       close_res;
    logic          is_dec_digit;
    logic          is_oct_digit;
    logic [3:0]    digit;
    logic [CW-1:0] byte_v;
    logic [CW-1:0] num_v;
    logic [CW-1:0] bslash_v;
    t_result       res [2];
    logic [1:0]    cnt;

    assign is_dec_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign is_oct_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_SEVEN);
    assign digit        = i_byte[3:0];
    assign byte_v       = CW'(i_byte);
    assign num_v        = CW'(r_num);
    assign bslash_v     = CW'(CH_BACKSLASH);

    always_comb begin
        close_res          = '0;
        close_res.kind     = KIND_END;
    end

    // decode one item against the current phase
    always_comb begin
        n_phase = r_phase;
        n_num   = r_num;
        res[0]  = '0;
        res[1]  = '0;
        cnt     = 2'd0;
        if (i_eoi) begin
            unique case (r_phase)
                PH_PLAIN: begin
                    res[0] = close_res;
                    cnt    = 2'd1;
                end
                PH_ESC: begin
                    res[0] = deliver(bslash_v, i_cfg);
                    res[1] = close_res;
                    cnt    = 2'd2;
                end
                PH_DEC, PH_OCT: begin
                    res[0] = deliver(num_v, i_cfg);
                    res[1] = close_res;
                    cnt    = 2'd2;
                end
                default: begin
                    res[0] = close_res;
                    cnt    = 2'd1;
                end
            endcase
            n_phase = PH_PLAIN;
            n_num   = '0;
        end else begin
            unique case (r_phase)
                PH_PLAIN: begin
                    if (i_byte == CH_BACKSLASH) begin
                        n_phase = PH_ESC;
                    end else begin
                        res[0] = deliver(byte_v, i_cfg);
                        cnt    = 2'd1;
                    end
                end
                PH_ESC: begin
                    n_phase = PH_PLAIN;
                    priority if (i_byte == CH_BACKSLASH) begin
                        res[0] = deliver(bslash_v, i_cfg);
                        cnt    = 2'd1;
                    end else if (i_byte == CH_BAR) begin
                        res[0] = deliver(CW'(i_cfg.bracket_code), i_cfg);
                        cnt    = 2'd1;
                    end else if (i_byte == CH_N) begin
                        res[0] = deliver(CW'(i_cfg.embedded_newline_code), i_cfg);
                        cnt    = 2'd1;
                    end else if (i_byte == CH_HASH || i_byte == CH_PERCENT) begin
                        n_phase = PH_DEC;
                        n_num   = '0;
                    end else if (is_dec_digit) begin
                        // a leading 8 or 9 still starts an octal number
                        n_phase = PH_OCT;
                        n_num   = VALUE_WIDTH'(digit);
                    end else begin
                        // lone backslash kept, byte decoded as plain text
                        res[0] = deliver(bslash_v, i_cfg);
                        res[1] = deliver(byte_v, i_cfg);
                        cnt    = 2'd2;
                    end
                end
                PH_DEC, PH_OCT: begin
                    if (r_phase == PH_DEC && is_dec_digit) begin
                        n_num = (r_num << 3) + (r_num << 1) + VALUE_WIDTH'(digit);
                    end else if (r_phase == PH_OCT && is_oct_digit) begin
                        n_num = (r_num << 3) + VALUE_WIDTH'(digit);
                    end else begin
                        // number ends, terminating byte decoded afresh
                        n_num  = '0;
                        res[0] = deliver(num_v, i_cfg);
                        if (i_byte == CH_BACKSLASH) begin
                            n_phase = PH_ESC;
                            cnt     = 2'd1;
                        end else begin
                            n_phase = PH_PLAIN;
                            res[1]  = deliver(byte_v, i_cfg);
                            cnt     = 2'd2;
                        end
                    end
                end
                default: begin
                    n_phase = PH_PLAIN;
                end
            endcase
        end
        // mark the final result of this item
        if (cnt == 2'd1) begin
            res[0].last = 1'b1;
        end else if (cnt == 2'd2) begin
            res[1].last = 1'b1;
        end
    end

    assign o_res_cnt = cnt;
    assign o_res[0]  = res[0];
    assign o_res[1]  = res[1];

    // escape state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_num   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_num   <= n_num;
        end
    end

endmodule

### rtl/core/esctok_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esctok_outbuf
// Three-slot result queue: takes up to two results per cycle while it holds at most
// one, and presents the oldest on the result channel.
// ----------------------------------------------------------------------------
module esctok_outbuf
    import esctok_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [1:0]    i_push_cnt,
    input  t_result       i_push_res [2],
    output logic          o_in_ready,
    esctok_out_if.source  o_out
);

    t_result    r_slot [3];
    t_result    n_slot [3];
    t_result    shifted [3];
    logic [1:0] r_count, n_count;
    logic [1:0] base;
    logic       pop;

    assign pop = (r_count != 2'd0) && o_out.ready;

    // room for a full two-result item while at most one result is held
    assign o_in_ready = (r_count <= 2'd1);

    // drop the head, then append behind the remaining items
    always_comb begin
        shifted[0] = pop ? r_slot[1] : r_slot[0];
        shifted[1] = pop ? r_slot[2] : r_slot[1];
        shifted[2] = r_slot[2];
        base       = r_count - {1'b0, pop};
        n_count    = base + i_push_cnt;
        for (int i = 0; i < 3; i++) begin
            n_slot[i] = shifted[i];
            if (i_push_cnt != 2'd0 && 2'(i) == base) begin
                n_slot[i] = i_push_res[0];
            end else if (i_push_cnt == 2'd2 && 2'(i) == base + 2'd1) begin
                n_slot[i] = i_push_res[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_slot[i] <= n_slot[i];
        end
    end

    assign o_out.valid    = (r_count != 2'd0);
    assign o_out.kind     = r_slot[0].kind;
    assign o_out.out_char = r_slot[0].out_char;
    assign o_out.line_end = r_slot[0].line_end;
    assign o_out.last     = r_slot[0].last;

endmodule

### rtl/core/escaped_text_tokenizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_text_tokenizer_core
// Backslash escape decoder and tokenizer for a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one raw byte per item, or an end-of-stream mark that flushes
//   any pending backslash or number and closes the current token.
//   o_out carries token characters (kind 0) and end-of-token marks (kind 1);
//   last flags the final result produced by an input item. The user must write
//   configuration (token mode, bracket code, embedded newline code) through
//   i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle; nothing enforces it.
// Timing:
//   the first result of an item reaches o_out in the cycle after it is accepted
//   when the queue is empty; otherwise it follows the results still waiting.
//   One item is taken every cycle while the three-slot result queue holds at
//   most one result; the queue drains one result per cycle while o_out.ready
//   is high, so items yielding two results can make i_in.ready drop.
// Reset:
//   synchronous; returns to plain text phase, clears the number accumulator
//   and the result queue, and restores the configuration reset values.
// Stall:
//   while o_out.ready is low results wait in the queue; i_in.ready drops as
//   soon as the queue holds two or more results.
// ----------------------------------------------------------------------------
module escaped_text_tokenizer_core
    import esctok_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    esctok_in_if.sink             i_in,
    esctok_out_if.source          o_out
);

    t_cfg       r_cfg;
    logic       accept;
    logic       in_ready;
    logic [1:0] res_cnt;
    logic [1:0] push_cnt;
    t_result    res [2];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.token_mode            <= 1'b0;
            r_cfg.bracket_code          <= BRACKET_RESET;
            r_cfg.embedded_newline_code <= EMBED_NL_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_TOKEN_MODE) begin
                r_cfg.token_mode <= i_cfg_data[0];
            end else if (i_cfg_idx == CFG_BRACKET) begin
                r_cfg.bracket_code <= i_cfg_data;
            end else if (i_cfg_idx == CFG_EMBED_NL) begin
                r_cfg.embedded_newline_code <= i_cfg_data;
            end
        end
    end

    assign i_in.ready = in_ready;
    assign accept     = i_in.valid && in_ready;
    assign push_cnt   = accept ? res_cnt : 2'd0;

    esctok_decode #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_byte    (i_in.in_byte),
        .i_eoi     (i_in.end_of_input),
        .i_cfg     (r_cfg),
        .o_res_cnt (res_cnt),
        .o_res     (res)
    );

    esctok_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_push_res (res),
        .o_in_ready (in_ready),
        .o_out      (o_out)
    );

endmodule
